### design/i2csbr_pkg.sv
// ----------------------------------------------------------------------------
// i2csbr_pkg
// Shared constants and types for the I2C snoop record decoder.
// ----------------------------------------------------------------------------
package i2csbr_pkg;

  // Record layout: appended bytes counted from 0, result taken after the last.
  localparam int unsigned RECORD_WRITES = 10;
  localparam int unsigned REC_FIRST     = 5;
  localparam int unsigned REC_BYTES     = 4;

  // Bus framing
  localparam int unsigned BITS_PER_BYTE = 9;   // eight data bits plus acknowledge
  localparam int unsigned DATA_BITS     = 8;
  localparam int unsigned STORE_BYTE    = 2;   // frame byte that is latched
  localparam int unsigned FRAME_LEN     = 3;   // frame length that feeds the record

  // Configuration
  localparam int unsigned IDLE_GAP_W    = 16;
  localparam logic [IDLE_GAP_W-1:0] IDLE_GAP_RESET = 16'd50;
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam logic [0:0] REG_IDLE_GAP   = 1'b0;   // register index 0

  // Stream widths
  localparam int unsigned IN_TDATA_W    = 8;
  localparam int unsigned OUT_TDATA_W   = 32;
  localparam int unsigned PRESS_W       = 10;
  localparam int unsigned HR_W          = 8;

  // Event queue between front and back
  localparam int unsigned QDEPTH        = 2;
  localparam int unsigned QPTR_W        = $clog2(QDEPTH);
  localparam int unsigned QCNT_W        = $clog2(QDEPTH + 1);

  // Snapshot of record bytes r5..r8, entry 0 is r5
  typedef logic [REC_BYTES-1:0][DATA_BITS-1:0] rec_t;

endpackage

### design/i2csbr_front.sv
// ----------------------------------------------------------------------------
// i2csbr_front
// Line sampling, START/STOP detection, byte assembly and record capture.
// ----------------------------------------------------------------------------
module i2csbr_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               sample_valid,
  input  logic                               scl,
  input  logic                               sda,
  input  logic [i2csbr_pkg::IDLE_GAP_W-1:0]  idle_gap,
  output logic                               push_valid,
  output i2csbr_pkg::rec_t                   push_data
);
  import i2csbr_pkg::*;

  logic                  scl_prev_r, scl_prev_nxt;
  logic                  sda_prev_r, sda_prev_nxt;
  logic [3:0]            bit_cnt_r, bit_cnt_nxt;
  logic [3:0]            frame_r, frame_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic [7:0]            third_r, third_nxt;
  logic [3:0]            rec_cnt_r, rec_cnt_nxt;
  rec_t                  rec_r, rec_nxt;
  logic [IDLE_GAP_W-1:0] idle_r, idle_nxt;
  logic                  act_r, act_nxt;

  logic                  scl_fall, scl_rise, scl_high, start_seen, stop_seen;
  logic [3:0]            bit_inc;
  logic [3:0]            rec_pos;
  logic                  push;

  assign scl_fall   = scl_prev_r & ~scl;
  assign scl_rise   = ~scl_prev_r & scl;
  assign scl_high   = scl_prev_r & scl;
  assign start_seen = scl_high & sda_prev_r & ~sda;
  assign stop_seen  = scl_high & ~sda_prev_r & sda;
  assign bit_inc    = bit_cnt_r + 4'd1;
  assign rec_pos    = rec_cnt_r - 4'(REC_FIRST);

  always_comb begin
    scl_prev_nxt = scl_prev_r;
    sda_prev_nxt = sda_prev_r;
    bit_cnt_nxt  = bit_cnt_r;
    frame_nxt    = frame_r;
    shift_nxt    = shift_r;
    third_nxt    = third_r;
    rec_cnt_nxt  = rec_cnt_r;
    rec_nxt      = rec_r;
    idle_nxt     = idle_r;
    act_nxt      = act_r;
    push         = 1'b0;
    if (sample_valid) begin
      scl_prev_nxt = scl;
      sda_prev_nxt = sda;
      // restart the quiet timer on an SCL fall, else count up and hold at top
      if (scl_fall) begin
        idle_nxt = '0;
      end else if (idle_r != '1) begin
        idle_nxt = idle_r + 1'b1;
      end
      if (scl_rise) begin
        shift_nxt = {shift_r[6:0], sda};
        act_nxt   = 1'b1;
        if (bit_inc == 4'(DATA_BITS) && frame_r == 4'(STORE_BYTE)) begin
          third_nxt = {shift_r[6:0], sda};
        end
        if (bit_inc >= 4'(BITS_PER_BYTE)) begin
          bit_cnt_nxt = '0;
          if (frame_r != 4'hf) begin
            frame_nxt = frame_r + 4'd1;
          end
        end else begin
          bit_cnt_nxt = bit_inc;
        end
      end
      if (start_seen) begin
        bit_cnt_nxt = '0;
        act_nxt     = 1'b1;
      end else if (stop_seen) begin
        act_nxt   = 1'b1;
        frame_nxt = '0;
        if (frame_r == 4'(FRAME_LEN)) begin
          if (rec_cnt_r >= 4'(REC_FIRST) && rec_cnt_r < 4'(REC_FIRST + REC_BYTES)) begin
            rec_nxt[rec_pos[1:0]] = third_r;
          end
          if (rec_cnt_r != 4'hf) begin
            rec_cnt_nxt = rec_cnt_r + 4'd1;
          end
          if (rec_cnt_nxt >= 4'(RECORD_WRITES)) begin
            push        = 1'b1;
            rec_cnt_nxt = '0;
          end
        end
      end
      // drop a partial record once the bus has gone quiet
      if (act_nxt && idle_nxt > idle_gap) begin
        rec_cnt_nxt = '0;
        act_nxt     = 1'b0;
      end
    end
  end

  assign push_valid = push;
  assign push_data  = rec_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_prev_r <= 1'b1;
      sda_prev_r <= 1'b1;
      bit_cnt_r  <= '0;
      frame_r    <= '0;
      shift_r    <= '0;
      third_r    <= '0;
      rec_cnt_r  <= '0;
      rec_r      <= '0;
      idle_r     <= '0;
      act_r      <= 1'b0;
    end else begin
      scl_prev_r <= scl_prev_nxt;
      sda_prev_r <= sda_prev_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      frame_r    <= frame_nxt;
      shift_r    <= shift_nxt;
      third_r    <= third_nxt;
      rec_cnt_r  <= rec_cnt_nxt;
      rec_r      <= rec_nxt;
      idle_r     <= idle_nxt;
      act_r      <= act_nxt;
    end
  end

endmodule

### design/i2csbr_queue.sv
// ----------------------------------------------------------------------------
// i2csbr_queue
// Short queue of completed records between front and back.
// ----------------------------------------------------------------------------
module i2csbr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2csbr_pkg::rec_t  push_data,
  output logic              full,
  output logic              head_valid,
  output i2csbr_pkg::rec_t  head_data,
  input  logic              pop
);
  import i2csbr_pkg::*;

  rec_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### design/i2csbr_back.sv
// ----------------------------------------------------------------------------
// i2csbr_back
// BCD decode of a completed record into the output register.
// ----------------------------------------------------------------------------
module i2csbr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  i2csbr_pkg::rec_t               head_data,
  output logic                           pop,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [i2csbr_pkg::PRESS_W-1:0] systolic,
  output logic [i2csbr_pkg::PRESS_W-1:0] diastolic,
  output logic [i2csbr_pkg::HR_W-1:0]    heart_rate
);
  import i2csbr_pkg::*;

  localparam logic [10:0] PRESSURE_MAX = 11'd999;

  logic               vld_r, vld_nxt;
  logic [PRESS_W-1:0] sys_r, dia_r;
  logic [HR_W-1:0]    hr_r;
  logic [10:0]        sys_sum, dia_sum;

  function automatic logic [10:0] bcd3(input logic [3:0] hund, input logic [7:0] tens);
    logic [10:0] v;
    v = 11'(hund) * 11'd100 + 11'(tens[7:4]) * 11'd10 + 11'(tens[3:0]);
    return v;
  endfunction

  assign sys_sum = bcd3(head_data[0][7:4], head_data[1]);
  assign dia_sum = bcd3(head_data[0][3:0], head_data[2]);

  // load a new result when the output register is free or being taken
  assign pop = head_valid && (!vld_r || res_ready);

  always_comb begin
    vld_nxt = vld_r;
    if (pop) begin
      vld_nxt = 1'b1;
    end else if (res_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sys_r <= (sys_sum > PRESSURE_MAX) ? PRESSURE_MAX[PRESS_W-1:0] : sys_sum[PRESS_W-1:0];
      dia_r <= (dia_sum > PRESSURE_MAX) ? PRESSURE_MAX[PRESS_W-1:0] : dia_sum[PRESS_W-1:0];
      hr_r  <= head_data[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign res_valid  = vld_r;
  assign systolic   = sys_r;
  assign diastolic  = dia_r;
  assign heart_rate = hr_r;

endmodule

### design/i2c_snoop_bcd_record_decoder.sv
// ----------------------------------------------------------------------------
// i2c_snoop_bcd_record_decoder
// Watches sampled SCL/SDA lines and decodes a blood-pressure record.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake             Payload
//  in_      in   in_tvalid/in_tready   tdata: scl_level, sda_level (one sample)
//  out_     out  out_tvalid/out_tready tdata: systolic, diastolic, heart_rate
//  cfg_     in   APB psel/penable      idle_gap at byte address 0
//
//  One line sample is taken per cycle while in_tready is high; a record
//  result is written into the queue on the STOP that completes it and is
//  then loaded into the output register. The front keeps sampling while
//  fewer than two results wait in the queue; in_tready drops whenever that
//  queue is full. Reset (synchronous, rst_n low) returns the bus to
//  idle-high and the idle gap register to 50; no clearing pass is needed.
//
module i2c_snoop_bcd_record_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  // stream in
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [i2csbr_pkg::IN_TDATA_W-1:0]   in_tdata,    // [0] scl_level, [1] sda_level
  // stream out
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [i2csbr_pkg::OUT_TDATA_W-1:0]  out_tdata,   // [9:0] systolic,
                                                           // [19:10] diastolic,
                                                           // [27:20] heart_rate
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [i2csbr_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [i2csbr_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [i2csbr_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                cfg_pready
);
  import i2csbr_pkg::*;

  logic [IDLE_GAP_W-1:0] idle_gap_r, idle_gap_nxt;
  logic                  cfg_wr;
  logic                  sample_valid;
  logic                  q_full, q_push, head_valid, q_pop;
  rec_t                  push_data, head_data;
  logic                  res_valid;
  logic [PRESS_W-1:0]    systolic, diastolic;
  logic [HR_W-1:0]       heart_rate;

  // configuration register: write completes in the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    idle_gap_nxt = idle_gap_r;
    if (cfg_wr && cfg_paddr[2] == REG_IDLE_GAP) begin
      idle_gap_nxt = cfg_pwdata[IDLE_GAP_W-1:0];
    end
  end

  // read back; addresses beyond the register read as zero
  assign cfg_prdata = (cfg_paddr[2] == REG_IDLE_GAP) ?
                      CFG_DATA_W'(idle_gap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_gap_r <= IDLE_GAP_RESET;
    end else begin
      idle_gap_r <= idle_gap_nxt;
    end
  end

  // hold samples only while the record queue has no room
  assign in_tready    = ~q_full;
  assign sample_valid = in_tvalid & in_tready;

  i2csbr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .scl          (in_tdata[0]),
    .sda          (in_tdata[1]),
    .idle_gap     (idle_gap_r),
    .push_valid   (q_push),
    .push_data    (push_data)
  );

  i2csbr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (push_data),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (q_pop)
  );

  i2csbr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (q_pop),
    .res_valid  (res_valid),
    .res_ready  (out_tready),
    .systolic   (systolic),
    .diastolic  (diastolic),
    .heart_rate (heart_rate)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {{(OUT_TDATA_W - 2*PRESS_W - HR_W){1'b0}},
                       heart_rate, diastolic, systolic};

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives line samples of a snooped I2C bus into the record decoder: EEPROM
// write frames that build complete blood-pressure records, plus broken,
// long, restarted and noisy traffic and quiet stretches. Every reading that
// leaves the block is compared field by field with a cycle-free model of
// the decoder kept here. The idle-gap register is swept between phases,
// and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  import i2csbr_pkg::*;

  localparam int unsigned HALF_PERIOD    = 5;
  localparam int unsigned RESET_CYCLES   = 4;
  localparam int unsigned MAX_WAIT       = 6;      // longest random idle per request
  localparam int unsigned SETTLE_CYCLES  = 32;     // let the output queue empty out
  localparam int unsigned HOLD_CYCLES    = 4000;   // long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 20000;  // cycles with no handshake at all
  localparam int unsigned MAX_REPORTS    = 40;
  localparam int unsigned PRESSURE_RECS  = 12;
  localparam int unsigned PHASE_COUNT    = 5;
  localparam int unsigned PHASE_RESULTS  = 8;
  localparam int unsigned EPISODE_CAP    = 30;
  localparam int unsigned PRESSURE_MAX   = 999;
  localparam logic [CFG_ADDR_W-1:0] ADDR_IDLE_GAP = CFG_ADDR_W'(4 * REG_IDLE_GAP);

  // One decoded reading, laid out as it sits in out_tdata
  typedef struct packed {
    logic [HR_W-1:0]    heart_rate;
    logic [PRESS_W-1:0] diastolic;
    logic [PRESS_W-1:0] systolic;
  } bp_reading_t;

  typedef enum logic [2:0] {
    DIR_RECORD,
    DIR_SHORT_FRAME,
    DIR_LONG_FRAME,
    DIR_RESTART,
    DIR_EDGES,
    DIR_IDLE_DROP,
    DIR_NOISE
  } dir_kind_e;

  typedef enum int unsigned {
    EP_RECORD,
    EP_FRAME,
    EP_BROKEN,
    EP_RESTART,
    EP_NOISE,
    EP_QUIET
  } episode_e;

  // One row of the directed table; want is only used where typed is set
  typedef struct packed {
    dir_kind_e   kind;
    rec_t        rec;
    logic        typed;
    bp_reading_t want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;     // [0] scl_level, [1] sda_level
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;    // [9:0] systolic, [19:10] diastolic,
                                        // [27:20] heart_rate
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  i2c_snoop_bcd_record_decoder u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Decoder model: bus edge tracking, frame assembly and the record store
  // --------------------------------------------------------------------------
  logic                  mon_scl_q, mon_sda_q;
  logic [3:0]            mon_bit_pos, mon_byte_cnt;
  logic [7:0]            mon_shift, mon_third;
  logic [3:0]            mon_rec_len;
  logic [7:0]            mon_rec [REC_BYTES];
  logic [15:0]           mon_quiet;
  logic                  mon_active;
  logic [IDLE_GAP_W-1:0] mon_idle_gap;

  bp_reading_t readings_q [$];        // readings still owed by the block
  int unsigned readings_predicted;
  int unsigned fail_count;

  // A directed row with a typed reading swaps it in for the modelled one
  logic        typed_pending;
  bp_reading_t typed_want;

  // Sender and receiver pacing
  logic        line_scl, line_sda;    // last line levels handed to the block
  logic        tx_fast;
  int unsigned tx_calm_left;
  logic        rx_hold_req;

  function automatic logic [PRESS_W-1:0] bcd_pressure(input logic [3:0] hundreds,
                                                      input logic [7:0] tens_units);
    int unsigned v;
    v = int'(hundreds) * 100 + int'(tens_units[7:4]) * 10 + int'(tens_units[3:0]);
    return (v > PRESSURE_MAX) ? PRESS_W'(PRESSURE_MAX) : PRESS_W'(v);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Advance the model by one accepted line sample
  task automatic decode_line(input logic scl, input logic sda);
    bp_reading_t got;
    int unsigned pos;
    // idle timer restarts on every SCL fall
    if (mon_scl_q && !scl)
      mon_quiet = '0;
    else if (mon_quiet != 16'hFFFF)
      mon_quiet++;

    // SCL rise: shift in a data bit, the ninth closes the byte
    if (!mon_scl_q && scl) begin
      mon_shift = {mon_shift[6:0], sda};
      mon_bit_pos++;
      if (mon_bit_pos == DATA_BITS && mon_byte_cnt == STORE_BYTE)
        mon_third = mon_shift;
      if (mon_bit_pos >= BITS_PER_BYTE) begin
        mon_bit_pos = '0;
        if (mon_byte_cnt != 4'hF)
          mon_byte_cnt++;
      end
      mon_active = 1'b1;
    end

    // START and STOP need SCL high on both samples
    if (mon_scl_q && scl) begin
      if (mon_sda_q && !sda) begin
        mon_bit_pos = '0;
        mon_active  = 1'b1;
      end else if (!mon_sda_q && sda) begin
        if (mon_byte_cnt == FRAME_LEN) begin
          pos = mon_rec_len;
          if (pos >= REC_FIRST && pos < REC_FIRST + REC_BYTES)
            mon_rec[pos - REC_FIRST] = mon_third;
          if (mon_rec_len != 4'hF)
            mon_rec_len++;
          if (mon_rec_len >= RECORD_WRITES) begin
            got.systolic   = bcd_pressure(mon_rec[0][7:4], mon_rec[1]);
            got.diastolic  = bcd_pressure(mon_rec[0][3:0], mon_rec[2]);
            got.heart_rate = mon_rec[3];
            readings_q.push_back(typed_pending ? typed_want : got);
            readings_predicted++;
            mon_rec_len = '0;
          end
        end
        mon_byte_cnt = '0;
        mon_active   = 1'b1;
      end
    end

    // a quiet bus drops a partial record, frame position is kept
    if (mon_active && mon_quiet > mon_idle_gap) begin
      mon_rec_len = '0;
      mon_active  = 1'b0;
    end
    mon_scl_q = scl;
    mon_sda_q = sda;
  endtask

  // --------------------------------------------------------------------------
  // Line-sample driver and bus-level sequences built on it
  // --------------------------------------------------------------------------

  // Offer one sample request; idle a random number of cycles first unless a
  // calm stretch or the pressure phase is running.
  task automatic put_line(input logic scl, input logic sda);
    int unsigned gap;
    if (tx_fast) begin
      gap = 0;
    end else if (tx_calm_left != 0) begin
      tx_calm_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, MAX_WAIT);
      if ($urandom_range(0, 99) == 0)
        tx_calm_left = $urandom_range(10, 120);
    end
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({sda, scl});
    do @(posedge clk); while (!in_tready);
    line_scl = scl;
    line_sda = sda;
    decode_line(scl, sda);
  endtask

  // Data bit: change SDA with SCL low, then raise SCL
  task automatic bus_bit(input logic b);
    put_line(1'b0, b);
    put_line(1'b1, b);
  endtask

  task automatic bus_byte(input logic [7:0] data, input logic ack);
    for (int i = 7; i >= 0; i--)
      bus_bit(data[i]);
    bus_bit(ack);
  endtask

  // Bring both lines high if needed (clocking one spare bit), then START
  task automatic bus_start();
    if (!(line_scl && line_sda)) begin
      if (line_scl)
        put_line(1'b0, line_sda);
      put_line(1'b0, 1'b1);
      put_line(1'b1, 1'b1);
    end
    put_line(1'b1, 1'b0);
    put_line(1'b0, 1'b0);
  endtask

  task automatic bus_stop();
    put_line(1'b0, 1'b0);
    put_line(1'b1, 1'b0);
    put_line(1'b1, 1'b1);
  endtask

  // Write frame of nbytes; the byte at the latch position carries third
  task automatic frame_write(input logic [7:0] third, input int unsigned nbytes);
    bus_start();
    for (int unsigned k = 0; k < nbytes; k++)
      bus_byte((k == STORE_BYTE) ? third : 8'($urandom), 1'($urandom));
    bus_stop();
  endtask

  // Ten three-byte frames; positions r5..r8 carry the record payload
  task automatic record_write(input rec_t rec);
    for (int unsigned p = 0; p < RECORD_WRITES; p++) begin
      if (p >= REC_FIRST && p < REC_FIRST + REC_BYTES)
        frame_write(rec[p - REC_FIRST], FRAME_LEN);
      else
        frame_write(8'($urandom), FRAME_LEN);
    end
  endtask

  task automatic hold_quiet(input int unsigned n);
    repeat (n) put_line(line_scl, line_sda);
  endtask

  task automatic noise(input int unsigned n);
    repeat (n) put_line(1'($urandom), 1'($urandom));
  endtask

  // Half the time proper BCD digits, otherwise any byte
  function automatic logic [7:0] rand_record_byte();
    if ($urandom_range(0, 1) == 0)
      return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    return 8'($urandom);
  endfunction

  function automatic rec_t rand_record();
    rec_t r;
    for (int k = 0; k < REC_BYTES; k++)
      r[k] = rand_record_byte();
    return r;
  endfunction

  function automatic dir_row_t mk_row(input dir_kind_e kind,
                                      input logic [7:0] r5, input logic [7:0] r6,
                                      input logic [7:0] r7, input logic [7:0] r8,
                                      input logic typed, input int unsigned sys,
                                      input int unsigned dia, input int unsigned hr);
    dir_row_t row;
    row.kind                 = kind;
    row.rec                  = {r8, r7, r6, r5};
    row.typed                = typed;
    row.want.systolic        = PRESS_W'(sys);
    row.want.diastolic       = PRESS_W'(dia);
    row.want.heart_rate      = HR_W'(hr);
    return row;
  endfunction

  // Stop offering, wait for every owed reading, then let the pipe settle
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (readings_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  task automatic cfg_read_check();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_IDLE_GAP;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("idle_gap", mon_idle_gap, cfg_prdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Only while idle: drain first, write, then read the value back
  task automatic set_idle_gap(input logic [IDLE_GAP_W-1:0] value);
    drain_results();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_IDLE_GAP;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    mon_idle_gap = value;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_read_check();
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random stalls, calm stretches, and one long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    int unsigned calm_left;
    bp_reading_t got;
    bp_reading_t want;
    calm_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_req) begin
        // hold off long enough for the result queue to fill and stall input
        rx_hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (calm_left != 0) begin
        calm_left--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 39) == 0)
          calm_left = $urandom_range(5, 30);
      end
      @(negedge clk);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata[$bits(bp_reading_t)-1:0];
      check_field("padding", 0, out_tdata[OUT_TDATA_W-1:$bits(bp_reading_t)]);
      if (readings_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $error("reading with none expected: systolic %0d diastolic %0d heart_rate %0d",
                 got.systolic, got.diastolic, got.heart_rate);
      end else begin
        want = readings_q.pop_front();
        check_field("systolic", want.systolic, got.systolic);
        check_field("diastolic", want.diastolic, got.diastolic);
        check_field("heart_rate", want.heart_rate, got.heart_rate);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: give up once no request moves on either stream for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    wait (rst_n === 1'b1);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  dir_row_t dir_rows [13];

  initial begin : stimulus
    logic [IDLE_GAP_W-1:0] phase_gap [PHASE_COUNT];
    int unsigned           phase_base;
    int unsigned           episodes;
    episode_e              ep;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;

    // model at reset: bus idle high, empty record
    mon_scl_q    = 1'b1;
    mon_sda_q    = 1'b1;
    mon_bit_pos  = '0;
    mon_byte_cnt = '0;
    mon_shift    = '0;
    mon_third    = '0;
    mon_rec_len  = '0;
    foreach (mon_rec[k]) mon_rec[k] = '0;
    mon_quiet    = '0;
    mon_active   = 1'b0;
    mon_idle_gap = IDLE_GAP_RESET;

    readings_predicted = 0;
    fail_count         = 0;
    typed_pending      = 1'b0;
    typed_want         = '0;
    line_scl           = 1'b1;
    line_sda           = 1'b1;
    tx_fast            = 1'b0;
    tx_calm_left       = 0;
    rx_hold_req        = 1'b0;

    // Directed part. Readings are typed in where the record fixes them:
    // all zero, all ones, plain BCD, exact 999, and the non-BCD nibbles
    // that push a pressure past 999. The rest is left to the model.
    dir_rows[0]  = mk_row(DIR_RECORD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 0, 0, 0);
    dir_rows[1]  = mk_row(DIR_RECORD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 999, 999, 255);
    dir_rows[2]  = mk_row(DIR_RECORD, 8'h12, 8'h34, 8'h56, 8'h78, 1'b1, 134, 256, 120);
    dir_rows[3]  = mk_row(DIR_RECORD, 8'h99, 8'h99, 8'h99, 8'h00, 1'b1, 999, 999, 0);
    dir_rows[4]  = mk_row(DIR_RECORD, 8'hA0, 8'h00, 8'h05, 8'h01, 1'b1, 999, 5, 1);
    dir_rows[5]  = mk_row(DIR_RECORD, 8'h09, 8'h0F, 8'hF0, 8'h80, 1'b1, 15, 999, 128);
    dir_rows[6]  = mk_row(DIR_SHORT_FRAME, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0, 0);
    dir_rows[7]  = mk_row(DIR_LONG_FRAME, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0, 0);
    dir_rows[8]  = mk_row(DIR_RESTART, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0, 0);
    dir_rows[9]  = mk_row(DIR_EDGES, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0, 0);
    dir_rows[10] = mk_row(DIR_IDLE_DROP, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0, 0);
    dir_rows[11] = mk_row(DIR_RECORD, 8'h31, 8'h20, 8'h80, 8'h48, 1'b0, 0, 0, 0);
    dir_rows[12] = mk_row(DIR_NOISE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 0, 0, 0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // idle gap must read back its reset value
    cfg_read_check();

    foreach (dir_rows[r]) begin
      typed_pending = dir_rows[r].typed;
      typed_want    = dir_rows[r].want;
      case (dir_rows[r].kind)
        DIR_RECORD: begin
          record_write(dir_rows[r].rec);
        end
        DIR_SHORT_FRAME: begin
          // two bytes only: must not reach the record
          frame_write(8'hA5, FRAME_LEN - 1);
        end
        DIR_LONG_FRAME: begin
          // enough bytes to saturate the frame byte count
          frame_write(8'h5A, 20);
        end
        DIR_RESTART: begin
          // START inside a byte resets the bit position, not the byte count
          bus_start();
          repeat (5) bus_bit(1'b1);
          frame_write(8'h3C, FRAME_LEN);
        end
        DIR_EDGES: begin
          // SCL and SDA moving together: bits only, no START or STOP,
          // then a proper STOP with no frame behind it
          put_line(1'b0, 1'b0);
          put_line(1'b1, 1'b1);
          put_line(1'b0, 1'b0);
          put_line(1'b0, 1'b1);
          put_line(1'b1, 1'b0);
          put_line(1'b1, 1'b1);
        end
        DIR_IDLE_DROP: begin
          // partial record, then a quiet stretch past the idle gap
          repeat (3) frame_write(8'h11, FRAME_LEN);
          hold_quiet(int'(IDLE_GAP_RESET) + 10);
        end
        DIR_NOISE: begin
          noise(25);
        end
        default: begin
        end
      endcase
      typed_pending = 1'b0;
    end

    // Pressure: idle gap at its top, sender at full rate, receiver holds off
    // after its next reading so the block backs up and stalls its input.
    set_idle_gap(16'hFFFF);
    tx_fast     = 1'b1;
    rx_hold_req = 1'b1;
    repeat (PRESSURE_RECS) record_write(rand_record());
    tx_fast = 1'b0;
    // pause the sender until every reading has come out
    drain_results();

    // Random phases, each with its own idle gap, lowest one included
    phase_gap[0] = 16'd1;
    phase_gap[1] = 16'($urandom_range(3, 60));
    phase_gap[2] = 16'($urandom_range(1, 65535));
    phase_gap[3] = 16'($urandom_range(61, 400));
    phase_gap[4] = IDLE_GAP_RESET;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      set_idle_gap(phase_gap[ph]);
      phase_base = readings_predicted;
      episodes   = 0;
      while (readings_predicted - phase_base < PHASE_RESULTS && episodes < EPISODE_CAP) begin
        // mostly well-formed records, the rest stray frames and line noise
        case ($urandom_range(0, 99)) inside
          [0:69]:  ep = EP_RECORD;
          [70:79]: ep = EP_FRAME;
          [80:84]: ep = EP_BROKEN;
          [85:89]: ep = EP_RESTART;
          [90:94]: ep = EP_NOISE;
          default: ep = EP_QUIET;
        endcase
        case (ep)
          EP_RECORD:  record_write(rand_record());
          EP_FRAME:   frame_write(8'($urandom), FRAME_LEN);
          EP_BROKEN:  frame_write(8'($urandom), $urandom_range(0, 18));
          EP_RESTART: begin
            bus_start();
            repeat ($urandom_range(1, 8)) bus_bit(1'($urandom));
            frame_write(8'($urandom), FRAME_LEN);
          end
          EP_NOISE:   noise($urandom_range(1, 30));
          default:    hold_quiet($urandom_range(1, 120));
        endcase
        episodes++;
      end
    end

    drain_results();
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### i2c_snoop_bcd_record_decoder.f
design/i2csbr_pkg.sv
design/i2csbr_front.sv
design/i2csbr_queue.sv
design/i2csbr_back.sv
design/i2c_snoop_bcd_record_decoder.sv
tb/sv/testbench.sv
